@@ hdl/strict_utf8_to_utf16_transcoder_assert.svh @@
// Assertion macros shared by the transcoder RTL.
// Depends on nothing; each module that checks itself includes this header.
`ifndef STRICT_UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define STRICT_UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define U8U16_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("u8u16 same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define U8U16_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("u8u16 next-cycle check failed");
`else
`define U8U16_ASSERT_IMP(name, ck, rs, ante, cons)
`define U8U16_ASSERT_NEXT(name, ck, rs, ante, cons)
`endif

`endif

@@ hdl/u8u16_pkg.sv @@
// Types and constants of the strict UTF-8 to UTF-16 transcoder.
// Depends on nothing; used by the decode core, the result queue and the top level.
package u8u16_pkg;

  localparam logic [8:0] MAX_OUTPUT_UNITS = 9'd256;
  localparam logic [8:0] CAP_RESET        = 9'd128;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
  localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
  localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
  localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
  localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
  localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] CP_SPACE    = 21'h000020;
  localparam logic [20:0] CP_DEL      = 21'h00007F;
  localparam logic [15:0] HIGH_SURR   = 16'hD800;
  localparam logic [15:0] LOW_SURR    = 16'hDC00;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_BAD_LEAD     = 4'd1,
    ST_BAD_CONT     = 4'd2,
    ST_TRUNCATED    = 4'd3,
    ST_BAD_CP       = 4'd4,
    ST_CAPACITY     = 4'd5,
    ST_UNTERMINATED = 4'd6,
    ST_EMPTY        = 4'd7,
    ST_PADDING      = 4'd8
  } status_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        is_status;
    status_t     status;
    logic        end_of_run;
  } result_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ hdl/u8u16_byte_if.sv @@
// Input channel of the transcoder: one UTF-8 byte per handshake.
// Depends on nothing.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ hdl/u8u16_result_if.sv @@
// Output channel of the transcoder: one UTF-16 unit or status word per handshake.
// Depends on nothing.
interface u8u16_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_unit;
  logic        is_status;
  logic [3:0]  status;
  logic        end_of_run;

  modport source (output valid, output out_unit, output is_status, output status,
                  output end_of_run, input ready);
  modport sink (input valid, input out_unit, input is_status, input status,
                input end_of_run, output ready);
endinterface

@@ hdl/u8u16_res_fifo.sv @@
// Small result queue that takes up to two words per cycle and hands out one.
// Depends on u8u16_pkg, u8u16_result_if and the assertion header.
`include "strict_utf8_to_utf16_transcoder_assert.svh"

module u8u16_res_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  u8u16_pkg::push_t       push,
  output logic                   space_ok,
  u8u16_result_if.source         out_ch
);

  u8u16_pkg::result_t                  entries [u8u16_pkg::RES_DEPTH];
  logic [u8u16_pkg::RES_PTR_W-1:0]     wptr;
  logic [u8u16_pkg::RES_PTR_W-1:0]     rptr;
  logic [u8u16_pkg::RES_CNT_W-1:0]     count;
  logic [u8u16_pkg::RES_CNT_W-1:0]     count_next;
  logic                                pop;
  logic [u8u16_pkg::RES_PTR_W-1:0]     wptr_plus1;

  assign pop        = out_ch.valid && out_ch.ready;
  assign wptr_plus1 = wptr + u8u16_pkg::RES_PTR_W'(1);
  assign space_ok   = count <= u8u16_pkg::RES_CNT_W'(u8u16_pkg::RES_DEPTH - 2);
  assign count_next = count + u8u16_pkg::RES_CNT_W'(push.num)
                      - u8u16_pkg::RES_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + u8u16_pkg::RES_PTR_W'(push.num);
      rptr  <= rptr + u8u16_pkg::RES_PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      entries[wptr_plus1] <= push.r1;
    end
  end

  assign out_ch.valid      = count != '0;
  assign out_ch.out_unit   = entries[rptr].out_unit;
  assign out_ch.is_status  = entries[rptr].is_status;
  assign out_ch.status     = entries[rptr].status;
  assign out_ch.end_of_run = entries[rptr].end_of_run;

  `U8U16_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= u8u16_pkg::RES_CNT_W'(u8u16_pkg::RES_DEPTH))
  `U8U16_ASSERT_IMP(a_push_has_room, clk, rst, push.num != 2'd0, space_ok)
  `U8U16_ASSERT_IMP(a_push_width, clk, rst, 1'b1, push.num != 2'd3)
  `U8U16_ASSERT_NEXT(a_count_step, clk, rst, 1'b1, count == $past(count_next))

endmodule

@@ hdl/u8u16_core.sv @@
// Decode core: input register, running UTF-8 decode state, capacity register
// and the combinational step that turns one byte into zero, one or two results.
// Depends on u8u16_pkg, u8u16_byte_if and the assertion header.
`include "strict_utf8_to_utf16_transcoder_assert.svh"

module u8u16_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data,
  input  logic              space_ok,
  output u8u16_pkg::push_t  push,
  u8u16_byte_if.sink        in_ch
);

  // Input register.
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        process;

  // Configuration and per-field state.
  logic [8:0]           capacity;
  logic [20:0]          pcp;
  logic [20:0]          pcp_next;
  logic [1:0]           cont_left;
  logic [1:0]           cont_left_next;
  logic [2:0]           seq_len;
  logic [2:0]           seq_len_next;
  logic [8:0]           units;
  logic [8:0]           units_next;
  logic                 term_seen;
  logic                 term_seen_next;
  u8u16_pkg::status_t   first_err;
  u8u16_pkg::status_t   first_err_next;

  // Step logic.
  logic [8:0]           cap_eff;
  logic                 fin_en;
  logic [20:0]          fin_cp;
  logic [2:0]           fin_len;
  logic                 fin_bad;
  logic [20:0]          supp;
  u8u16_pkg::status_t   final_st;

  assign process     = s1_valid && space_ok;
  assign in_ch.ready = !s1_valid || space_ok;
  assign cap_eff     = (capacity > u8u16_pkg::MAX_OUTPUT_UNITS) ?
                       u8u16_pkg::MAX_OUTPUT_UNITS : capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      capacity <= u8u16_pkg::CAP_RESET;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid <= 1'b1;
      end else if (process) begin
        s1_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.in_byte;
      s1_last <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcp       <= '0;
      cont_left <= '0;
      seq_len   <= '0;
      units     <= '0;
      term_seen <= 1'b0;
      first_err <= u8u16_pkg::ST_OK;
    end else if (process) begin
      pcp       <= pcp_next;
      cont_left <= cont_left_next;
      seq_len   <= seq_len_next;
      units     <= units_next;
      term_seen <= term_seen_next;
      first_err <= first_err_next;
    end
  end

  // Final status of a field, in priority order.
  always_comb begin
    if (first_err != u8u16_pkg::ST_OK) begin
      final_st = first_err;
    end else if (term_seen) begin
      final_st = (s1_byte != 8'd0) ? u8u16_pkg::ST_PADDING : u8u16_pkg::ST_OK;
    end else if (s1_byte != 8'd0) begin
      final_st = u8u16_pkg::ST_UNTERMINATED;
    end else if (cont_left != 2'd0) begin
      final_st = u8u16_pkg::ST_TRUNCATED;
    end else if (units == 9'd0) begin
      final_st = u8u16_pkg::ST_EMPTY;
    end else begin
      final_st = u8u16_pkg::ST_OK;
    end
  end

  always_comb begin
    pcp_next       = pcp;
    cont_left_next = cont_left;
    seq_len_next   = seq_len;
    units_next     = units;
    term_seen_next = term_seen;
    first_err_next = first_err;
    fin_en         = 1'b0;
    fin_cp         = '0;
    fin_len        = 3'd1;
    push           = '0;

    if (s1_last) begin
      pcp_next       = '0;
      cont_left_next = '0;
      seq_len_next   = '0;
      units_next     = '0;
      term_seen_next = 1'b0;
      first_err_next = u8u16_pkg::ST_OK;
      push.num       = 2'd1;
      push.r0.is_status  = 1'b1;
      push.r0.status     = final_st;
      push.r0.end_of_run = 1'b1;
    end else if (first_err != u8u16_pkg::ST_OK) begin
      // Errors are sticky until the field ends.
    end else if (term_seen) begin
      if (s1_byte != 8'd0) begin
        first_err_next = u8u16_pkg::ST_PADDING;
      end
    end else if (s1_byte == 8'd0) begin
      if (cont_left != 2'd0) begin
        first_err_next = u8u16_pkg::ST_TRUNCATED;
      end else if (units == 9'd0) begin
        first_err_next = u8u16_pkg::ST_EMPTY;
      end
      term_seen_next = 1'b1;
    end else if (cont_left != 2'd0) begin
      if (s1_byte[7:6] != 2'b10) begin
        first_err_next = u8u16_pkg::ST_BAD_CONT;
      end else begin
        pcp_next       = {pcp[14:0], s1_byte[5:0]};
        cont_left_next = cont_left - 2'd1;
        if (cont_left == 2'd1) begin
          fin_en  = 1'b1;
          fin_cp  = {pcp[14:0], s1_byte[5:0]};
          fin_len = seq_len;
        end
      end
    end else if (!s1_byte[7]) begin
      fin_en  = 1'b1;
      fin_cp  = {13'd0, s1_byte};
      fin_len = 3'd1;
    end else if (s1_byte >= u8u16_pkg::LEAD2_MIN && s1_byte <= u8u16_pkg::LEAD2_MAX) begin
      pcp_next       = {16'd0, s1_byte[4:0]};
      seq_len_next   = 3'd2;
      cont_left_next = 2'd1;
    end else if (s1_byte >= u8u16_pkg::LEAD3_MIN && s1_byte <= u8u16_pkg::LEAD3_MAX) begin
      pcp_next       = {17'd0, s1_byte[3:0]};
      seq_len_next   = 3'd3;
      cont_left_next = 2'd2;
    end else if (s1_byte >= u8u16_pkg::LEAD4_MIN && s1_byte <= u8u16_pkg::LEAD4_MAX) begin
      pcp_next       = {18'd0, s1_byte[2:0]};
      seq_len_next   = 3'd4;
      cont_left_next = 2'd3;
    end else begin
      first_err_next = u8u16_pkg::ST_BAD_LEAD;
    end

    // A completed code point is range-checked, then emitted if it fits.
    fin_bad = (fin_len == 3'd2 && fin_cp < 21'h000080) ||
              (fin_len == 3'd3 && fin_cp < 21'h000800) ||
              (fin_len == 3'd4 && fin_cp < u8u16_pkg::SUPP_BASE) ||
              (fin_cp > u8u16_pkg::CP_MAX) ||
              (fin_cp >= u8u16_pkg::SURR_LO && fin_cp <= u8u16_pkg::SURR_HI) ||
              (fin_cp < u8u16_pkg::CP_SPACE) || (fin_cp == u8u16_pkg::CP_DEL);
    supp = fin_cp - u8u16_pkg::SUPP_BASE;

    if (fin_en) begin
      seq_len_next = '0;
      pcp_next     = '0;
      if (fin_bad) begin
        first_err_next = u8u16_pkg::ST_BAD_CP;
      end else if (fin_cp < u8u16_pkg::SUPP_BASE) begin
        if ({1'b0, units} + 10'd1 >= {1'b0, cap_eff}) begin
          first_err_next = u8u16_pkg::ST_CAPACITY;
        end else begin
          push.num           = 2'd1;
          push.r0.out_unit   = fin_cp[15:0];
          push.r0.end_of_run = 1'b1;
          units_next         = units + 9'd1;
        end
      end else begin
        if ({1'b0, units} + 10'd2 >= {1'b0, cap_eff}) begin
          first_err_next = u8u16_pkg::ST_CAPACITY;
        end else begin
          push.num           = 2'd2;
          push.r0.out_unit   = u8u16_pkg::HIGH_SURR | {6'd0, supp[19:10]};
          push.r1.out_unit   = u8u16_pkg::LOW_SURR | {6'd0, supp[9:0]};
          push.r1.end_of_run = 1'b1;
          units_next         = units + 9'd2;
        end
      end
    end

    if (!process) begin
      push.num = 2'd0;
    end
  end

  `U8U16_ASSERT_NEXT(a_field_clears, clk, rst, process && s1_last, units == 9'd0 && !term_seen && first_err == u8u16_pkg::ST_OK)
  `U8U16_ASSERT_IMP(a_pair_is_units, clk, rst, push.num == 2'd2, !push.r0.is_status && !push.r1.is_status)
  `U8U16_ASSERT_IMP(a_no_units_after_err, clk, rst, process && first_err != u8u16_pkg::ST_OK, push.num == 2'd0 || s1_last)
  `U8U16_ASSERT_IMP(a_units_bound, clk, rst, 1'b1, units < u8u16_pkg::MAX_OUTPUT_UNITS)

endmodule

@@ hdl/strict_utf8_to_utf16_transcoder.sv @@
// A byte accepted on in_ch is held in the input register; while the four-entry result
// queue has room it is decoded and its results, two for a surrogate pair, are written
// there and offered on out_ch. One UTF-8 byte per cycle is taken while there is room.
// Reset (rst, synchronous) clears decode state and the queue and sets capacity to 128.
// Top level of the strict UTF-8 to UTF-16 transcoder.
// Depends on u8u16_pkg, both channel interfaces, u8u16_core and u8u16_res_fifo.
module strict_utf8_to_utf16_transcoder (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [8:0]    cfg_wr_data,
  u8u16_byte_if.sink    in_ch,
  u8u16_result_if.source out_ch
);

  u8u16_pkg::push_t push;
  logic             space_ok;

  u8u16_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .space_ok    (space_ok),
    .push        (push),
    .in_ch       (in_ch)
  );

  u8u16_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .out_ch   (out_ch)
  );

endmodule
